// ===== hw/rtl/tfr_pkg.sv =====
`default_nettype none

package tfr_pkg;

  // Default geometry of the frame store
  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;
  localparam int GLYPH_W     = 6;

  // Command codes carried on in_tuser
  localparam logic [2:0] CMD_PLACE_AT  = 3'd0;
  localparam logic [2:0] CMD_PLACE_CUR = 3'd1;
  localparam logic [2:0] CMD_CLEAR     = 3'd2;
  localparam logic [2:0] CMD_FILL      = 3'd3;
  localparam logic [2:0] CMD_REFRESH   = 3'd4;

  // Refresh stream bytes
  localparam logic [7:0] CTRL_CMD   = 8'h00;
  localparam logic [7:0] CTRL_DATA  = 8'h40;
  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] CMD_COL_LO = 8'h00;

  // Framing flags of one stream byte
  typedef struct packed {
    logic frame_end;
    logic txn_end;
    logic txn_start;
  } tfr_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/text_framebuffer_renderer_top.sv =====
`default_nettype none

// Refresh tick: enters ST_RESP, then registers the byte onto out_tdata when the output
// register is free; no new command is taken until then. Glyph placement: six store writes
// if the glyph fits on screen, else dropped. Clear and fill: one store write per cycle
// over PAGES * 2**clog2(COLUMNS) entries (1024 at default size); other codes are ignored.
// Reset: synchronous, active low; afterward a clearing pass of the same length as clear
// zeroes the store, with in_tready low during it.
module text_framebuffer_renderer_top #(
  parameter int COLUMNS = tfr_pkg::COLUMNS_DEF,
  parameter int PAGES   = tfr_pkg::PAGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // column[6:0], page_row[9:7], char_code[17:10],
                                       // fill_byte[25:18], zero pad
  input  wire logic [2:0]  in_tuser,   // cmd[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,  // tx_byte[7:0]
  output logic      [1:0]  out_tuser,  // txn_start[0], txn_end[1]
  output logic             out_tlast   // frame_end
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int AW    = PW + CW;
  localparam int DEPTH = PAGES * (2 ** CW);

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_DRAW  = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] sweep_addr_r, sweep_addr_nxt;
  logic [7:0]    sweep_data_r, sweep_data_nxt;
  logic [2:0]    draw_idx_r, draw_idx_nxt;
  logic [CW-1:0] draw_col_r, draw_col_nxt;
  logic [PW-1:0] draw_page_r, draw_page_nxt;
  logic [7:0]    char_r, char_nxt;
  logic [7:0]    cursor_col_r, cursor_col_nxt;
  logic [2:0]    cursor_page_r, cursor_page_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  tfr_pkg::tfr_flags_t out_flags_r, out_flags_nxt;

  logic [6:0] f_column;
  logic [2:0] f_page_row;
  logic [7:0] f_char_code;
  logic [7:0] f_fill_byte;
  logic       in_acc;

  logic [7:0] pl_col;
  logic [2:0] pl_page;
  logic [4:0] pl_page_w;
  logic       pl_ok;
  logic [8:0] pl_next;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic [CW-1:0] draw_wcol;
  logic [7:0]    glyph_byte;

  logic          rf_step;
  logic [PW-1:0] rf_page;
  logic [CW-1:0] rf_col;
  logic [7:0]    rf_byte;
  tfr_pkg::tfr_flags_t rf_flags;

  assign f_column    = in_tdata[6:0];
  assign f_page_row  = in_tdata[9:7];
  assign f_char_code = in_tdata[17:10];
  assign f_fill_byte = in_tdata[25:18];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Placement target and on-screen check
  always_comb begin
    if (in_tuser == tfr_pkg::CMD_PLACE_AT) begin
      pl_col  = {1'b0, f_column};
      pl_page = f_page_row;
    end else begin
      pl_col  = cursor_col_r;
      pl_page = cursor_page_r;
    end
    pl_page_w = {2'b00, pl_page};
    pl_ok     = (pl_page_w < 5'(PAGES)) &&
                ({1'b0, pl_col} <= 9'(COLUMNS - tfr_pkg::GLYPH_W));
    pl_next   = {1'b0, pl_col} + 9'(tfr_pkg::GLYPH_W);
  end

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    sweep_addr_nxt  = sweep_addr_r;
    sweep_data_nxt  = sweep_data_r;
    draw_idx_nxt    = draw_idx_r;
    draw_col_nxt    = draw_col_r;
    draw_page_nxt   = draw_page_r;
    char_nxt        = char_r;
    cursor_col_nxt  = cursor_col_r;
    cursor_page_nxt = cursor_page_r;
    rf_step         = 1'b0;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_byte_nxt    = out_byte_r;
    out_flags_nxt   = out_flags_r;
    case (state_r)
      ST_SWEEP: begin
        sweep_addr_nxt = sweep_addr_r + AW'(1);
        if (sweep_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            tfr_pkg::CMD_PLACE_AT, tfr_pkg::CMD_PLACE_CUR: begin
              if (pl_ok) begin
                state_nxt       = ST_DRAW;
                draw_idx_nxt    = 3'd0;
                draw_col_nxt    = pl_col[CW-1:0];
                draw_page_nxt   = pl_page_w[PW-1:0];
                char_nxt        = f_char_code;
                cursor_col_nxt  = pl_next[8] ? 8'hFF : pl_next[7:0];
                cursor_page_nxt = pl_page;
              end
            end
            tfr_pkg::CMD_CLEAR: begin
              state_nxt      = ST_SWEEP;
              sweep_addr_nxt = '0;
              sweep_data_nxt = 8'h00;
            end
            tfr_pkg::CMD_FILL: begin
              state_nxt      = ST_SWEEP;
              sweep_addr_nxt = '0;
              sweep_data_nxt = f_fill_byte;
            end
            tfr_pkg::CMD_REFRESH: begin
              state_nxt = ST_RESP;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_DRAW: begin
        draw_idx_nxt = draw_idx_r + 3'd1;
        if (draw_idx_r == 3'(tfr_pkg::GLYPH_W - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESP: begin
        // Store data for this position was read when the tick was taken
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rf_byte;
          out_flags_nxt = rf_flags;
          rf_step       = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_SWEEP;
      sweep_addr_r  <= '0;
      sweep_data_r  <= 8'h00;
      cursor_col_r  <= 8'h00;
      cursor_page_r <= 3'd0;
      out_valid_r   <= 1'b0;
      draw_idx_r    <= 3'd0;
    end else begin
      state_r       <= state_nxt;
      sweep_addr_r  <= sweep_addr_nxt;
      sweep_data_r  <= sweep_data_nxt;
      cursor_col_r  <= cursor_col_nxt;
      cursor_page_r <= cursor_page_nxt;
      out_valid_r   <= out_valid_nxt;
      draw_idx_r    <= draw_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    draw_col_r  <= draw_col_nxt;
    draw_page_r <= draw_page_nxt;
    char_r      <= char_nxt;
    out_byte_r  <= out_byte_nxt;
    out_flags_r <= out_flags_nxt;
  end

  // Store write port: sweep or glyph column
  assign draw_wcol = draw_col_r + CW'(draw_idx_r);
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr_r;
    mem_wdata = sweep_data_r;
    if (state_r == ST_SWEEP) begin
      mem_we = 1'b1;
    end else if (state_r == ST_DRAW) begin
      mem_we    = 1'b1;
      mem_waddr = {draw_page_r, draw_wcol};
      mem_wdata = glyph_byte;
    end
  end

  assign mem_raddr = {rf_page, rf_col};

  tfr_glyph u_glyph (
    .char_code  (char_r),
    .col_idx    (draw_idx_r),
    .glyph_byte (glyph_byte)
  );

  tfr_store #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tfr_refresh #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES),
    .CW      (CW),
    .PW      (PW)
  ) u_refresh (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (rf_step),
    .rdata   (mem_rdata),
    .rd_page (rf_page),
    .rd_col  (rf_col),
    .tx_byte (rf_byte),
    .flags   (rf_flags)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_flags_r.txn_end, out_flags_r.txn_start};
  assign out_tlast  = out_flags_r.frame_end;

  // Checks
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("store written while idle");

  a_tick_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == tfr_pkg::CMD_REFRESH) |=> (state_r == ST_RESP))
    else $error("refresh tick did not start a response");

  a_draw_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAW) |-> (draw_idx_r <= 3'(tfr_pkg::GLYPH_W - 1)))
    else $error("glyph column index out of range");

  a_frame_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tuser[1] && !out_tuser[0]))
    else $error("frame end on a byte that does not close a transaction");

endmodule

`default_nettype wire

// ===== hw/rtl/tfr_store.sv =====
`default_nettype none

module tfr_store #(
  parameter int AW    = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/tfr_glyph.sv =====
`default_nettype none

module tfr_glyph (
  input  wire logic [7:0] char_code,
  input  wire logic [2:0] col_idx,
  output logic      [7:0] glyph_byte
);

  // Rows hold column 0 in the top byte down to column 5 in the low byte
  localparam logic [47:0] ROM [42] = '{
    48'h000000000000, 48'h006060000000, 48'h003636000000, 48'h080808080800,
    48'h808080808000, 48'h626408132300, 48'h3E5149453E00, 48'h00427F400000,
    48'h426151494600, 48'h2141454B3100, 48'h1814127F1000, 48'h274545453900,
    48'h3C4A49493000, 48'h017109050300, 48'h364949493600, 48'h064949291E00,
    48'h7E1111117E00, 48'h7F4949493600, 48'h3E4141412200, 48'h7F4141221C00,
    48'h7F4949494100, 48'h7F0909090100, 48'h3E4149497A00, 48'h7F0808087F00,
    48'h00417F410000, 48'h2040413F0100, 48'h7F0814224100, 48'h7F4040404000,
    48'h7F020C027F00, 48'h7F0408107F00, 48'h3E4141413E00, 48'h7F0909090600,
    48'h3E4151215E00, 48'h7F1929294600, 48'h464949493100, 48'h01017F010100,
    48'h3F4040403F00, 48'h1F2040201F00, 48'h7F2018207F00, 48'h631408146300,
    48'h030478040300, 48'h615149454300
  };

  logic [5:0]  idx;
  logic [47:0] row;
  logic [5:0]  shift;

  // Character code to glyph number; unsupported codes map to blank
  always_comb begin
    idx = 6'd0;
    if (char_code >= 8'h30 && char_code <= 8'h39) begin
      idx = 6'(char_code - 8'h30) + 6'd6;
    end else if (char_code >= 8'h41 && char_code <= 8'h5A) begin
      idx = 6'(char_code - 8'h41) + 6'd16;
    end else begin
      case (char_code)
        8'h2E:   idx = 6'd1;
        8'h3A:   idx = 6'd2;
        8'h2D:   idx = 6'd3;
        8'h5F:   idx = 6'd4;
        8'h25:   idx = 6'd5;
        default: idx = 6'd0;
      endcase
    end
  end

  // Column select within the glyph row
  always_comb begin
    row   = ROM[idx];
    shift = 6'(6'd40 - {col_idx, 3'b000});
    glyph_byte = row[shift +: 8];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tfr_refresh.sv =====
`default_nettype none

module tfr_refresh #(
  parameter int COLUMNS = tfr_pkg::COLUMNS_DEF,
  parameter int PAGES   = tfr_pkg::PAGES_DEF,
  parameter int CW      = $clog2(COLUMNS),
  parameter int PW      = (PAGES > 1) ? $clog2(PAGES) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic [7:0]         rdata,
  output logic      [PW-1:0]      rd_page,
  output logic      [CW-1:0]      rd_col,
  output logic      [7:0]         tx_byte,
  output tfr_pkg::tfr_flags_t     flags
);

  localparam int QW     = $clog2(COLUMNS + 7);
  localparam int LAST_Q = COLUMNS + 6;

  logic [PW-1:0] page_r, page_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic          last_page;

  assign last_page = (page_r == PW'(PAGES - 1));
  assign rd_page   = page_r;
  assign rd_col    = CW'(q_r - QW'(7));

  // Byte and framing at the current stream position
  always_comb begin
    tx_byte         = tfr_pkg::CTRL_CMD;
    flags.txn_start = 1'b0;
    flags.txn_end   = 1'b0;
    flags.frame_end = 1'b0;
    if (q_r < QW'(6)) begin
      flags.txn_start = ~q_r[0];
      flags.txn_end   = q_r[0];
      if (q_r == QW'(1)) begin
        tx_byte = tfr_pkg::CMD_PAGE + 8'(page_r);
      end else if (q_r == QW'(3)) begin
        tx_byte = tfr_pkg::CMD_COL_HI;
      end else if (q_r == QW'(5)) begin
        tx_byte = tfr_pkg::CMD_COL_LO;
      end
    end else if (q_r == QW'(6)) begin
      tx_byte         = tfr_pkg::CTRL_DATA;
      flags.txn_start = 1'b1;
    end else begin
      tx_byte = rdata;
      if (q_r == QW'(LAST_Q)) begin
        flags.txn_end   = 1'b1;
        flags.frame_end = last_page;
      end
    end
  end

  // Position advance with page and frame wrap
  always_comb begin
    page_nxt = page_r;
    q_nxt    = q_r;
    if (step) begin
      if (q_r == QW'(LAST_Q)) begin
        q_nxt    = '0;
        page_nxt = last_page ? '0 : page_r + PW'(1);
      end else begin
        q_nxt = q_r + QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r <= '0;
      q_r    <= '0;
    end else begin
      page_r <= page_nxt;
      q_r    <= q_nxt;
    end
  end

endmodule

`default_nettype wire
